/* src/mwa_pkg.sv */
// Package: shared constants for the moving window average core.
`default_nettype none

package mwa_pkg;

    // Width of the window size register.
    localparam int WINDOW_BITS = 7;

    // Window size after reset.
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd64;

endpackage : mwa_pkg

`default_nettype wire

/* src/moving_window_average_core.sv */
// Moving window average core: ring store of samples, exact running sum, serial divider.
//
// Each accepted item carries one signed Q16.16 sample. The core keeps the most recent
// window_size samples in a ring store with their exact running sum. Once the window is
// full, the oldest sample drops out before the new one goes in. Each item returns one
// result, the running sum divided by window_size and truncated toward zero. The divisor
// is always the full window size, even while the window is still filling, so early
// results are scaled down. A window_size of zero acts as one, and a value above
// MAX_WINDOW acts as MAX_WINDOW. Writing window_size clears the fill count and the sum.
// The write index and the store contents are kept. Write it only while the core is idle.
// The oldest sample is read from the store at the accepting edge. The update state then
// updates the sum and writes the new sample, and the init state loads the divider. A
// radix-2 restoring divider then yields one quotient bit per cycle for each bit of the
// sum, and a final state loads the output register. A new item is not accepted until the
// previous result has been loaded into the output register. in_stall is low only while no
// item is in progress. A finished result waits in the output register, and the next item
// can be accepted during that wait. There is no clearing pass after reset. The fill count
// only lets the core read entries written since the last clear.
`default_nettype none

module moving_window_average_core #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // configuration
    input  wire                                   window_size_we,
    input  wire        [mwa_pkg::WINDOW_BITS-1:0] window_size,
    // input channel
    input  wire                                   in_valid,
    output logic                                  in_stall,
    input  wire signed [SAMPLE_BITS-1:0]          sample,
    // output channel
    output logic                                  out_valid,
    input  wire                                   out_stall,
    output logic signed [SAMPLE_BITS-1:0]         average
);

    localparam int WB   = mwa_pkg::WINDOW_BITS;
    // Store index width; a single-entry store still gets one bit.
    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    // The fill count runs from 0 to MAX_WINDOW inclusive.
    localparam int FW   = $clog2(MAX_WINDOW + 1);
    // Common width for window and fill comparisons.
    localparam int WCMP = (WB > FW) ? WB : FW;
    // The sum of MAX_WINDOW samples fits exactly.
    localparam int SUMW = SAMPLE_BITS + $clog2(MAX_WINDOW);
    // The divide counter runs from SUMW down to 1.
    localparam int CW   = $clog2(SUMW + 1);

    localparam logic [AW:0]     MAX_IDX  = (AW + 1)'(MAX_WINDOW);
    localparam logic [AW-1:0]   LAST_IDX = AW'(MAX_WINDOW - 1);
    localparam logic [WCMP-1:0] MAX_CMP  = WCMP'(MAX_WINDOW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_INIT,
        S_DIV,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [WB-1:0]            window_reg;
    logic [FW-1:0]            fill_reg;
    logic [AW-1:0]            wr_idx_reg;
    logic signed [SUMW-1:0]   sum_reg;
    logic                     sub_reg;
    logic [CW-1:0]            cnt_reg;
    logic                     out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] average_reg;

    // datapath registers, no reset
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0]   rd_data_reg;
    logic [WB-1:0]            div_reg;
    logic [WB-1:0]            rem_reg;
    logic [SUMW-1:0]          quo_reg;
    logic                     neg_reg;

    // ring store
    logic [SAMPLE_BITS-1:0]   mem [MAX_WINDOW];

    logic                     in_acc;
    logic [WB-1:0]            win_eff;
    logic [WCMP-1:0]          win_cmp;
    logic                     need_sub;
    logic [AW-1:0]            back;
    logic [AW-1:0]            old_idx;
    logic signed [SUMW-1:0]   old_ext;
    logic signed [SUMW-1:0]   new_ext;
    logic signed [SUMW-1:0]   sum_next;
    logic [WB:0]              rem_shift;
    logic                     q_bit;
    logic [WB:0]              rem_sub;
    logic [SUMW-1:0]          quo_signed;
    logic [AW-1:0]            wr_idx_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign average   = average_reg;

    // Effective window: zero acts as one, large values saturate.
    always_comb
    begin
        win_cmp = WCMP'(window_reg);
        if (window_reg == '0)
        begin
            win_cmp = WCMP'(1);
        end
        else if (win_cmp > MAX_CMP)
        begin
            win_cmp = MAX_CMP;
        end
        win_eff = WB'(win_cmp);
    end

    assign need_sub = (WCMP'(fill_reg) >= win_cmp);

    // Oldest entry sits fill_count places behind the write index, modulo the store depth.
    always_comb
    begin
        back = (WCMP'(fill_reg) == MAX_CMP) ? '0 : AW'(fill_reg);
        if (wr_idx_reg >= back)
        begin
            old_idx = wr_idx_reg - back;
        end
        else
        begin
            old_idx = AW'((AW + 1)'(wr_idx_reg) + MAX_IDX - (AW + 1)'(back));
        end
    end

    assign old_ext  = SUMW'(signed'(rd_data_reg));
    assign new_ext  = SUMW'(sample_reg);
    assign sum_next = sum_reg - (sub_reg ? old_ext : '0) + new_ext;

    assign wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + AW'(1);

    // one restoring divide step
    assign rem_shift  = {rem_reg, quo_reg[SUMW-1]};
    assign q_bit      = (rem_shift >= {1'b0, div_reg});
    assign rem_sub    = q_bit ? (rem_shift - {1'b0, div_reg}) : rem_shift;
    assign quo_signed = neg_reg ? (~quo_reg + SUMW'(1)) : quo_reg;

    // store: read at acceptance, write during the update cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPD)
        begin
            mem[wr_idx_reg] <= sample_reg;
        end
        if (in_acc)
        begin
            rd_data_reg <= mem[old_idx];
        end
    end

    // divider and item datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sample_reg <= sample;
            div_reg    <= win_eff;
        end
        if (state_reg == S_INIT)
        begin
            neg_reg <= sum_reg[SUMW-1];
            quo_reg <= sum_reg[SUMW-1] ? (~sum_reg + SUMW'(1)) : sum_reg;
            rem_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            quo_reg <= {quo_reg[SUMW-2:0], q_bit};
            rem_reg <= rem_sub[WB-1:0];
        end
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= mwa_pkg::WINDOW_RESET;
            fill_reg      <= '0;
            wr_idx_reg    <= '0;
            sum_reg       <= '0;
            sub_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            average_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        sub_reg   <= need_sub;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    sum_reg    <= sum_next;
                    wr_idx_reg <= wr_idx_next;
                    if (!sub_reg)
                    begin
                        fill_reg <= fill_reg + FW'(1);
                    end
                    state_reg <= S_INIT;
                end
                S_INIT:
                begin
                    cnt_reg   <= CW'(SUMW);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // hold the result until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        average_reg   <= SAMPLE_BITS'(quo_signed);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // register write, idle only: the user must keep to this; the block does not enforce it
            if (window_size_we)
            begin
                window_reg <= window_size;
                fill_reg   <= '0;
                sum_reg    <= '0;
            end
        end
    end

    // fill count never passes the effective window
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WCMP'(fill_reg) <= win_cmp)
        else $error("fill count above window");

    // divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ({1'b0, rem_reg} < {1'b0, div_reg}))
        else $error("divider remainder out of range");

    // an accepted item keeps the input side stalled next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (in_stall && state_reg == S_UPD))
        else $error("item not taken into update");

    // a pending result is not dropped while the output register is held
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("result lost while output stalled");

endmodule : moving_window_average_core

`default_nettype wire
